/* hdl/uri_component_tokenizer_top_macros.svh */
// Assertion macros for the URI component tokenizer.
// Included by the modules that carry concurrent checks.
`ifndef URI_COMPONENT_TOKENIZER_TOP_MACROS_SVH
`define URI_COMPONENT_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UCT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("uct check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UCT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("uct check failed");

`endif

/* hdl/uct_pkg.sv */
// Shared types, codes and character constants for the URI tokenizer.
// No dependencies.
package uct_pkg;

    localparam int unsigned PortW = 16;
    localparam logic [PortW-1:0] DefaultPort = 16'd80;
    localparam logic [PortW-1:0] PortMax = 16'hFFFF;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_SCHEME = 3'd1;
    localparam logic [2:0] PH_SLASH  = 3'd2;
    localparam logic [2:0] PH_NETLOC = 3'd3;
    localparam logic [2:0] PH_PATH   = 3'd4;
    localparam logic [2:0] PH_FRAG   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_ERROR  = 3'd7;

    localparam logic [2:0] CL_SKIP   = 3'd0;
    localparam logic [2:0] CL_SCHEME = 3'd1;
    localparam logic [2:0] CL_SEP    = 3'd2;
    localparam logic [2:0] CL_HOST   = 3'd3;
    localparam logic [2:0] CL_PORT   = 3'd4;
    localparam logic [2:0] CL_PATH   = 3'd5;
    localparam logic [2:0] CL_FRAG   = 3'd6;
    localparam logic [2:0] CL_IGNORE = 3'd7;

    localparam logic [2:0] ST_RUN       = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_BAD_START = 3'd2;
    localparam logic [2:0] ST_NO_COLON  = 3'd3;
    localparam logic [2:0] ST_EMPTY_NET = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       char_class;
        logic [2:0]       status;
        logic [PortW-1:0] port_number;
        logic             path_empty;
        logic             has_fragment;
        logic             end_of_string;
    } out_word_t;

    typedef struct packed {
        logic [2:0]       phase;
        logic [PortW-1:0] port_accum;
        logic             port_open;
        logic             port_closed;
        logic             netloc_nonempty;
        logic             path_nonempty;
        logic             frag_nonempty;
        logic [2:0]       error_code;
    } parse_state_t;

    localparam parse_state_t StateInit = '{
        phase:           PH_LEAD,
        port_accum:      '0,
        port_open:       1'b0,
        port_closed:     1'b0,
        netloc_nonempty: 1'b0,
        path_nonempty:   1'b0,
        frag_nonempty:   1'b0,
        error_code:      ST_RUN
    };

endpackage

/* hdl/uct_next.sv */
// Per-character next-state and result logic of the URI tokenizer.
// Depends on uct_pkg.
module uct_next (
    input  uct_pkg::parse_state_t st,
    input  uct_pkg::in_word_t     word,
    input  logic [15:0]           default_port,
    output uct_pkg::parse_state_t st_next,
    output uct_pkg::out_word_t    res
);
    import uct_pkg::*;

    function automatic parse_state_t finish(input parse_state_t s);
        parse_state_t r;
        r = s;
        case (s.phase)
            PH_LEAD: begin
                r.phase = PH_ERROR;
                r.error_code = ST_BAD_START;
            end
            PH_SCHEME: begin
                r.phase = PH_ERROR;
                r.error_code = ST_NO_COLON;
            end
            PH_SLASH: begin
                r.phase = PH_ERROR;
                r.error_code = ST_EMPTY_NET;
            end
            PH_ERROR: begin
                r.phase = PH_ERROR;
            end
            default: begin
                r.phase = PH_DONE;
            end
        endcase
        return r;
    endfunction

    logic [7:0]       c;
    logic             stop;
    logic             is_alpha;
    logic             is_digit;
    logic             is_scheme_ch;
    logic [19:0]      port_mac;
    logic [2:0]       cls;
    parse_state_t     s1;
    parse_state_t     s2;

    assign c = word.ch;
    assign stop = (c == CH_SPACE) || (c == CH_LF);
    assign is_alpha = c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
    assign is_digit = c inside {[CH_ZERO:CH_NINE]};
    assign is_scheme_ch = is_alpha || is_digit || (c == CH_PLUS) || (c == CH_MINUS)
                          || (c == CH_DOT);
    // acc * 10 + digit
    assign port_mac = {1'b0, st.port_accum, 3'b000} + {3'b000, st.port_accum, 1'b0}
                      + {16'd0, c[3:0]};

    always_comb begin
        s1 = st;
        cls = CL_IGNORE;
        if (c == CH_NUL) begin
            s1 = finish(st);
        end else begin
            case (st.phase)
                PH_LEAD: begin
                    if (c == CH_SPACE) begin
                        cls = CL_SKIP;
                    end else if (!is_alpha) begin
                        s1.phase = PH_ERROR;
                        s1.error_code = ST_BAD_START;
                    end else begin
                        s1.phase = PH_SCHEME;
                        cls = CL_SCHEME;
                    end
                end
                PH_SCHEME: begin
                    if (is_scheme_ch) begin
                        cls = CL_SCHEME;
                    end else if (c == CH_COLON) begin
                        s1.phase = PH_SLASH;
                        cls = CL_SEP;
                    end else begin
                        s1.phase = PH_ERROR;
                        s1.error_code = ST_NO_COLON;
                    end
                end
                PH_SLASH: begin
                    if (c == CH_SLASH) begin
                        cls = CL_SEP;
                    end else if (stop) begin
                        s1.phase = PH_ERROR;
                        s1.error_code = ST_EMPTY_NET;
                    end else begin
                        s1.netloc_nonempty = 1'b1;
                        s1.phase = PH_NETLOC;
                        if (c == CH_COLON) begin
                            s1.port_open = 1'b1;
                            cls = CL_SEP;
                        end else begin
                            cls = CL_HOST;
                        end
                    end
                end
                PH_NETLOC: begin
                    if (c == CH_SLASH) begin
                        s1.phase = PH_PATH;
                        s1.path_nonempty = 1'b1;
                        cls = CL_PATH;
                    end else if (stop) begin
                        s1.phase = PH_DONE;
                    end else if (!st.port_open) begin
                        if (c == CH_COLON) begin
                            s1.port_open = 1'b1;
                            cls = CL_SEP;
                        end else begin
                            cls = CL_HOST;
                        end
                    end else if (!st.port_closed && is_digit) begin
                        s1.port_accum = (port_mac > {4'd0, PortMax}) ? PortMax
                                        : port_mac[PortW-1:0];
                        cls = CL_PORT;
                    end else begin
                        s1.port_closed = 1'b1;
                    end
                end
                PH_PATH: begin
                    if (c == CH_HASH) begin
                        s1.phase = PH_FRAG;
                        cls = CL_SEP;
                    end else if (stop) begin
                        s1.phase = PH_DONE;
                    end else begin
                        s1.path_nonempty = 1'b1;
                        cls = CL_PATH;
                    end
                end
                PH_FRAG: begin
                    if (stop) begin
                        s1.phase = PH_DONE;
                    end else begin
                        s1.frag_nonempty = 1'b1;
                        cls = CL_FRAG;
                    end
                end
                default: begin
                    cls = CL_IGNORE;
                end
            endcase
        end
    end

    always_comb begin
        s2 = word.last ? finish(s1) : s1;
        res.char_class = cls;
        res.status = s2.error_code;
        res.port_number = '0;
        res.path_empty = 1'b0;
        res.has_fragment = 1'b0;
        res.end_of_string = word.last;
        if (word.last && (s2.error_code == ST_RUN)) begin
            res.status = ST_OK;
            res.port_number = (s2.port_accum != '0) ? s2.port_accum : default_port;
            res.path_empty = !s2.path_nonempty;
            res.has_fragment = s2.frag_nonempty;
        end
        st_next = word.last ? StateInit : s2;
    end

endmodule

/* hdl/uct_tracker.sv */
// Parse state and default port registers of the URI tokenizer.
// Depends on uct_pkg and uct_next.
`include "uri_component_tokenizer_top_macros.svh"

module uct_tracker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  logic               step,
    input  uct_pkg::in_word_t  word,
    output uct_pkg::out_word_t res
);
    import uct_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;
    logic [PortW-1:0] dport_reg;

    uct_next u_next (
        .st           (st_reg),
        .word         (word),
        .default_port (dport_reg),
        .st_next      (st_next),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= StateInit;
            dport_reg <= DefaultPort;
        end else begin
            if (step) begin
                st_reg <= st_next;
            end
            if (cfg_valid) begin
                dport_reg <= cfg_data;
            end
        end
    end

    `UCT_ASSERT_NXT(a_clear_after_last, aclk, aresetn, step && word.last,
        st_reg.phase == PH_LEAD && st_reg.error_code == ST_RUN)
    `UCT_ASSERT_IMP(a_err_phase, aclk, aresetn, st_reg.error_code != ST_RUN,
        st_reg.phase == PH_ERROR)
    `UCT_ASSERT_IMP(a_ok_only_last, aclk, aresetn, step && res.status == ST_OK,
        res.end_of_string)

endmodule

/* hdl/uri_component_tokenizer_top.sv */
// URI component tokenizer: one character word in, one tagged result word out per cycle while
// m_ready does not stall; the word is held in in_word_reg, its result in out_word_reg.
// The per-character state update sets the rate. Depends on uct_pkg and uct_tracker.
`include "uri_component_tokenizer_top_macros.svh"

module uri_component_tokenizer_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  uct_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output uct_pkg::out_word_t m_data
);
    import uct_pkg::*;

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t res;
    logic      step;

    assign cfg_ready = 1'b1;
    assign step = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_data = out_word_reg;

    uct_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step      (step),
        .word      (in_word_reg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (step) begin
            out_word_reg <= res;
        end
    end

    `UCT_ASSERT_IMP(a_mid_fields_zero, aclk, aresetn, m_valid && !m_data.end_of_string,
        m_data.port_number == '0 && !m_data.path_empty && !m_data.has_fragment)
    `UCT_ASSERT_NXT(a_in_hold, aclk, aresetn, in_valid_reg && !step, in_valid_reg)
    `UCT_ASSERT_NXT(a_out_fill, aclk, aresetn, in_valid_reg && !out_valid_reg,
        out_valid_reg)

endmodule
